FILE: rtl/core/rgtc_pkg.sv
// ---------------------------------------------------------------------------
// rgtc_pkg
// Shared types and constants for the tipping-bucket rain gauge counter.
// ---------------------------------------------------------------------------
package rgtc_pkg;

    localparam logic [1:0] OP_TIP   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_ARM   = 2'd3;

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_STARTUP  = 2'd1;
    localparam logic [1:0] REG_WINDOW   = 2'd2;
    localparam logic [1:0] REG_UM       = 2'd3;

    localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
    localparam int QUOT_W = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TIP,
        ST_SCAN_ADDR,
        ST_SCAN,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic do_tip;
        logic do_clear;
        logic do_arm;
        logic scan_init;
        logic scan_step;
        logic mul1;
        logic mul2;
        logic div_step;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic div_last;
    } dp_stat_t;

endpackage

FILE: rtl/core/rgtc_ctrl.sv
// ---------------------------------------------------------------------------
// rgtc_ctrl
// Sequencer: clear, arm, tip update, ring scan, rate multiply and restoring divide.
// ---------------------------------------------------------------------------
module rgtc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        operation,
    input  rgtc_pkg::dp_stat_t stat,
    output logic              busy,
    output rgtc_pkg::dp_cmd_t cmd
);
    import rgtc_pkg::*;

    state_t state_reg, state_next;

    // advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_TIP:  state_next = ST_TIP;
                        OP_READ: state_next = ST_SCAN_ADDR;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TIP:       state_next = ST_IDLE;
            ST_SCAN_ADDR: state_next = ST_SCAN;
            ST_SCAN:      state_next = stat.scan_last ? ST_MUL1 : ST_SCAN;
            ST_MUL1:      state_next = ST_MUL2;
            ST_MUL2:      state_next = ST_DIV;
            ST_DIV:       state_next = stat.div_last ? ST_DONE : ST_DIV;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.latch_in = start;
                cmd.do_clear = start && (operation == OP_CLEAR);
                cmd.do_arm   = start && (operation == OP_ARM);
                cmd.scan_init = start && (operation == OP_READ);
            end
            ST_TIP:       cmd.do_tip = 1'b1;
            ST_SCAN_ADDR: cmd.scan_step = 1'b0;
            ST_SCAN:      cmd.scan_step = 1'b1;
            ST_MUL1:      cmd.mul1 = 1'b1;
            ST_MUL2:      cmd.mul2 = 1'b1;
            ST_DIV:       cmd.div_step = 1'b1;
            ST_DONE:      cmd.emit = 1'b1;
            default:      cmd = '0;
        endcase
    end

endmodule

FILE: rtl/core/rgtc_dp.sv
// ---------------------------------------------------------------------------
// rgtc_dp
// Datapath: counters, timestamp ring, window scan, rate arithmetic.
// ---------------------------------------------------------------------------
module rgtc_dp
#(
    parameter int TIP_SLOTS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        now_ms,
    input  logic [15:0]        debounce_ms,
    input  logic [7:0]         startup_ignored,
    input  logic [26:0]        window_ms,
    input  logic [15:0]        um_per_tip,
    input  rgtc_pkg::dp_cmd_t  cmd,
    output rgtc_pkg::dp_stat_t stat,
    output logic               done,
    output logic [31:0]        total_tips,
    output logic [15:0]        ignored_tips,
    output logic [6:0]         tips_in_window,
    output logic [31:0]        last_gap_ms,
    output logic [47:0]        total_rain_um,
    output logic [47:0]        rain_rate_um_per_hour,
    output logic               is_raining
);
    import rgtc_pkg::*;

    localparam int SW = (TIP_SLOTS > 1) ? $clog2(TIP_SLOTS) : 1;

    logic [31:0]    ring [TIP_SLOTS];
    logic [TIP_SLOTS-1:0] valid_reg;
    logic [SW-1:0]  wslot_reg;
    logic [31:0]    last_time_reg, last_gap_reg, tips_reg, now_reg;
    logic [15:0]    ign_reg;
    logic           armed_reg, have_reg;

    logic [SW:0]    scan_idx_reg;
    logic [31:0]    rd_data_reg;
    logic           rd_valid_reg;
    logic           rd_live_reg;
    logic [6:0]     count_reg;
    logic [22:0]    cu_reg;
    logic [26:0]    divisor_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [27:0]    rem_reg;
    logic [6:0]     div_cnt_reg;
    logic           done_reg;
    logic [47:0]    rain_reg;

    logic [31:0] since;
    logic        tip_take, tip_count;
    assign since     = now_reg - last_time_reg;
    assign tip_take  = !have_reg || (since > {16'd0, debounce_ms});
    assign tip_count = armed_reg && (ign_reg >= {8'd0, startup_ignored});

    // latch input time
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
            now_reg <= now_ms;
    end

    // control state: counters, flags, ring pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            wslot_reg     <= '0;
            last_time_reg <= '0;
            last_gap_reg  <= '0;
            tips_reg      <= '0;
            ign_reg       <= '0;
            armed_reg     <= 1'b0;
            have_reg      <= 1'b0;
        end
        else if (cmd.do_clear)
        begin
            tips_reg      <= '0;
            ign_reg       <= '0;
            last_gap_reg  <= '0;
            last_time_reg <= '0;
            have_reg      <= 1'b0;
            armed_reg     <= 1'b0;
        end
        else if (cmd.do_arm)
            armed_reg <= 1'b1;
        else if (cmd.do_tip && tip_take)
        begin
            last_gap_reg  <= have_reg ? since : 32'd0;
            last_time_reg <= now_reg;
            have_reg      <= 1'b1;
            if (!tip_count)
            begin
                if (ign_reg != 16'hFFFF)
                    ign_reg <= ign_reg + 16'd1;
            end
            else
            begin
                tips_reg             <= tips_reg + 32'd1;
                valid_reg[wslot_reg] <= 1'b1;
                if (wslot_reg == SW'(TIP_SLOTS - 1))
                    wslot_reg <= '0;
                else
                    wslot_reg <= wslot_reg + SW'(1);
            end
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.do_tip && tip_take && tip_count)
            ring[wslot_reg] <= now_reg;
        rd_data_reg <= ring[scan_idx_reg[SW-1:0]];
    end

    // scan ring one slot per cycle
    logic [31:0] age;
    assign age = now_reg - rd_data_reg;
    assign stat.scan_last = (scan_idx_reg == (SW+1)'(TIP_SLOTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            rd_live_reg  <= 1'b0;
            count_reg    <= '0;
        end
        else if (cmd.scan_init)
        begin
            scan_idx_reg <= '0;
            rd_live_reg  <= 1'b0;
            count_reg    <= '0;
        end
        else if (cmd.scan_step || (!rd_live_reg && scan_idx_reg == '0))
        begin
            if (!stat.scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + (SW+1)'(1);
                rd_valid_reg <= valid_reg[scan_idx_reg[SW-1:0]];
            end
            rd_live_reg <= !stat.scan_last;
            if (rd_live_reg && rd_valid_reg && age <= {5'd0, window_ms}
                && count_reg != 7'd127)
                count_reg <= count_reg + 7'd1;
        end
    end

    // rate: count*um, then *3600000, then restoring divide
    logic [27:0] rem_sh;
    logic [26:0] div_eff;
    assign div_eff = (window_ms == '0) ? 27'd1 : window_ms;
    assign rem_sh  = {rem_reg[26:0], quot_reg[QUOT_W-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            cu_reg   <= {16'd0, count_reg} * {7'd0, um_per_tip};
            rain_reg <= {16'd0, tips_reg} * {32'd0, um_per_tip};
        end
        if (cmd.mul2)
        begin
            quot_reg    <= {{(QUOT_W-23){1'b0}}, cu_reg}
                         * {{(QUOT_W-22){1'b0}}, MS_PER_HOUR};
            rem_reg     <= '0;
            divisor_reg <= div_eff;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, divisor_reg})
            begin
                rem_reg  <= rem_sh - {1'b0, divisor_reg};
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + 7'd1;
        end
    end
    assign stat.div_last = (div_cnt_reg == 7'(QUOT_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    // results
    assign done                  = done_reg;
    assign total_tips            = tips_reg;
    assign ignored_tips          = ign_reg;
    assign tips_in_window        = count_reg;
    assign last_gap_ms           = last_gap_reg;
    assign total_rain_um         = rain_reg;
    assign rain_rate_um_per_hour = (quot_reg[QUOT_W-1:48] != '0) ? 48'hFFFF_FFFF_FFFF
                                                                 : quot_reg[47:0];
    assign is_raining            = (count_reg != '0);

endmodule

FILE: rtl/core/rain_gauge_tip_counter.sv
// Sequence: clear and arm apply from idle, a tip passes through ST_TIP, and a read ends with done.
// Throughput: one transaction at a time; a read is set by the one-slot-per-cycle
// ring scan and the one-bit-per-cycle 64-step divider.
// Reset: rst_n asynchronous, clears counters, valid bits and registers to defaults.
// Results are held on the ports while done pulses; the receiver cannot stall.
// ---------------------------------------------------------------------------
// rain_gauge_tip_counter
// Tipping-bucket rain gauge counter with APB configuration registers.
// ---------------------------------------------------------------------------
module rain_gauge_tip_counter
#(
    parameter int TIP_SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [31:0] now_ms,
    output logic        done,
    output logic [31:0] total_tips,
    output logic [15:0] ignored_tips,
    output logic [6:0]  tips_in_window,
    output logic [31:0] last_gap_ms,
    output logic [47:0] total_rain_um,
    output logic [47:0] rain_rate_um_per_hour,
    output logic        is_raining
);
    import rgtc_pkg::*;

    logic [15:0] debounce_reg, um_reg;
    logic [7:0]  startup_reg;
    logic [26:0] window_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= 16'd50;
            startup_reg  <= 8'd1;
            window_reg   <= 27'd3600000;
            um_reg       <= 16'd280;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_DEBOUNCE: debounce_reg <= pwdata[15:0];
                REG_STARTUP:  startup_reg  <= pwdata[7:0];
                REG_WINDOW:   window_reg   <= pwdata[26:0];
                REG_UM:       um_reg       <= pwdata[15:0];
                default:      debounce_reg <= debounce_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_DEBOUNCE: prdata = {16'd0, debounce_reg};
            REG_STARTUP:  prdata = {24'd0, startup_reg};
            REG_WINDOW:   prdata = {5'd0, window_reg};
            REG_UM:       prdata = {16'd0, um_reg};
            default:      prdata = '0;
        endcase
    end

    rgtc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .stat      (stat),
        .busy      (busy),
        .cmd       (cmd)
    );

    rgtc_dp #(.TIP_SLOTS(TIP_SLOTS)) u_dp
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .now_ms                (now_ms),
        .debounce_ms           (debounce_reg),
        .startup_ignored       (startup_reg),
        .window_ms             (window_reg),
        .um_per_tip            (um_reg),
        .cmd                   (cmd),
        .stat                  (stat),
        .done                  (done),
        .total_tips            (total_tips),
        .ignored_tips          (ignored_tips),
        .tips_in_window        (tips_in_window),
        .last_gap_ms           (last_gap_ms),
        .total_rain_um         (total_rain_um),
        .rain_rate_um_per_hour (rain_rate_um_per_hour),
        .is_raining            (is_raining)
    );

endmodule
